// ===== design/r2b_pkg.sv =====
// Package for the RGB565 to 24-bit BMP stream encoder.
// Holds the command type passed from front to back, header byte positions
// and the channel scaling tables. No dependencies.
`default_nettype none

package r2b_pkg;

	localparam int DIM_W  = 12;
	localparam int POS_W  = 6;
	localparam int ROW_W  = 14;
	localparam int PROD_W = ROW_W + DIM_W;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd240;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd176;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam int HDR_LEN = 54;

	localparam logic [POS_W-1:0] HP_MAGIC0  = 6'd0;
	localparam logic [POS_W-1:0] HP_MAGIC1  = 6'd1;
	localparam logic [POS_W-1:0] HP_SIZE0   = 6'd2;
	localparam logic [POS_W-1:0] HP_SIZE1   = 6'd3;
	localparam logic [POS_W-1:0] HP_SIZE2   = 6'd4;
	localparam logic [POS_W-1:0] HP_SIZE3   = 6'd5;
	localparam logic [POS_W-1:0] HP_OFFSET  = 6'd10;
	localparam logic [POS_W-1:0] HP_INFO    = 6'd14;
	localparam logic [POS_W-1:0] HP_WIDTH0  = 6'd18;
	localparam logic [POS_W-1:0] HP_WIDTH1  = 6'd19;
	localparam logic [POS_W-1:0] HP_HEIGHT0 = 6'd22;
	localparam logic [POS_W-1:0] HP_HEIGHT1 = 6'd23;
	localparam logic [POS_W-1:0] HP_PLANES  = 6'd26;
	localparam logic [POS_W-1:0] HP_BPP     = 6'd28;
	localparam logic [POS_W-1:0] P_BLUE     = 6'd54;
	localparam logic [POS_W-1:0] P_GREEN    = 6'd55;
	localparam logic [POS_W-1:0] P_RED      = 6'd56;

	localparam logic [7:0] MAGIC_B     = 8'h42;
	localparam logic [7:0] MAGIC_M     = 8'h4D;
	localparam logic [7:0] OFFSET_BYTE = 8'd54;
	localparam logic [7:0] INFO_BYTE   = 8'd40;
	localparam logic [7:0] PLANES_BYTE = 8'd1;
	localparam logic [7:0] BPP_BYTE    = 8'd24;

	localparam int Max5 = 31;
	localparam int Max6 = 63;

	typedef logic [7:0] scale5_tab_t [32];
	typedef logic [7:0] scale6_tab_t [64];

	function automatic scale5_tab_t mk_scale5();
		scale5_tab_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'((i * 255) / Max5);
		end
		return t;
	endfunction

	function automatic scale6_tab_t mk_scale6();
		scale6_tab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'((i * 255) / Max6);
		end
		return t;
	endfunction

	localparam scale5_tab_t SCALE5 = mk_scale5();
	localparam scale6_tab_t SCALE6 = mk_scale6();

	typedef struct packed {
		logic             header;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [7:0]       blue;
		logic [7:0]       green;
		logic [7:0]       red;
		logic [POS_W-1:0] last_pos;
		logic             frame_end;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

endpackage

`default_nettype wire

// ===== design/r2b_pix_if.sv =====
// Pixel channel interface: valid/ready with one RGB565 pixel.
// No dependencies.
`default_nettype none

interface r2b_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== design/r2b_byte_if.sv =====
// Byte channel interface: valid/ready with one BMP stream byte and flags.
// No dependencies.
`default_nettype none

interface r2b_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       frame_done;

	modport source (output valid, output out_byte, output last_of_run, output frame_done,
		input ready);
	modport sink (input valid, input out_byte, input last_of_run, input frame_done,
		output ready);
endinterface

`default_nettype wire

// ===== design/r2b_front.sv =====
// Front end: accepts pixels, tracks column/row/header state, builds commands.
// Depends on r2b_pkg and r2b_pix_if.
`default_nettype none

module r2b_front import r2b_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	r2b_pix_if.sink          pix,
	input  logic [DIM_W-1:0] dim_w,
	input  logic [DIM_W-1:0] dim_h,
	input  logic             full,
	output logic             push,
	output cmd_t             push_cmd
);

	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic             hdr_pend_q;
	logic             row_end;
	logic             frame_end;

	assign pix.ready = !full;
	assign push      = pix.valid && !full;

	assign row_end   = ({1'b0, col_q} + 13'd1) >= {1'b0, dim_w};
	assign frame_end = row_end && (({1'b0, row_q} + 13'd1) >= {1'b0, dim_h});

	always_comb begin
		push_cmd.header    = hdr_pend_q;
		push_cmd.width     = dim_w;
		push_cmd.height    = dim_h;
		push_cmd.blue      = SCALE5[pix.pixel[4:0]];
		push_cmd.green     = SCALE6[pix.pixel[10:5]];
		push_cmd.red       = SCALE5[pix.pixel[15:11]];
		push_cmd.last_pos  = row_end ? (P_RED + POS_W'(dim_w[1:0])) : P_RED;
		push_cmd.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			hdr_pend_q <= 1'b1;
		end else if (push) begin
			hdr_pend_q <= frame_end;
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/r2b_fifo.sv =====
// Short command queue between front and back end.
// Depends on r2b_pkg.
`default_nettype none

module r2b_fifo import r2b_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic head_valid,
	output logic full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head       = mem_q[rd_q];
	assign head_valid = cnt_q != '0;
	assign full       = cnt_q == CNT_W'(DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("queue underflow");

endmodule

`default_nettype wire

// ===== design/r2b_back.sv =====
// Back end: steps through header, pixel and padding bytes of each command
// into the output register. Depends on r2b_pkg and r2b_byte_if.
`default_nettype none

module r2b_back import r2b_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_valid,
	output logic       pop,
	r2b_byte_if.source bmp
);

	bk_state_t         state_q;
	bk_state_t         state_d;
	cmd_t              cur_q;
	logic [POS_W-1:0]  pos_q;
	logic [PROD_W-1:0] prod_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic              fd_q;
	logic              valid_q;
	logic              slot_free;
	logic              emit;
	logic              done;
	logic              load;
	logic [7:0]        byte_d;
	logic [31:0]       fsize;
	logic [ROW_W-1:0]  padrow;

	assign bmp.valid       = valid_q;
	assign bmp.out_byte    = byte_q;
	assign bmp.last_of_run = last_q;
	assign bmp.frame_done  = fd_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head_valid) state_d = BK_RUN;
			end
			BK_RUN: begin
				if (emit && done && !head_valid) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		slot_free = !valid_q || bmp.ready;
		emit      = (state_q == BK_RUN) && slot_free;
		done      = pos_q == cur_q.last_pos;
		load      = head_valid && ((state_q == BK_IDLE) || (emit && done));
		pop       = load;
		padrow    = ROW_W'({cur_q.width, 1'b0}) + ROW_W'(cur_q.width)
			+ ROW_W'(cur_q.width[1:0]);
		fsize     = 32'(prod_q) + 32'(HDR_LEN);
		unique case (pos_q)
			HP_MAGIC0:  byte_d = MAGIC_B;
			HP_MAGIC1:  byte_d = MAGIC_M;
			HP_SIZE0:   byte_d = fsize[7:0];
			HP_SIZE1:   byte_d = fsize[15:8];
			HP_SIZE2:   byte_d = fsize[23:16];
			HP_SIZE3:   byte_d = fsize[31:24];
			HP_OFFSET:  byte_d = OFFSET_BYTE;
			HP_INFO:    byte_d = INFO_BYTE;
			HP_WIDTH0:  byte_d = cur_q.width[7:0];
			HP_WIDTH1:  byte_d = {4'd0, cur_q.width[11:8]};
			HP_HEIGHT0: byte_d = cur_q.height[7:0];
			HP_HEIGHT1: byte_d = {4'd0, cur_q.height[11:8]};
			HP_PLANES:  byte_d = PLANES_BYTE;
			HP_BPP:     byte_d = BPP_BYTE;
			P_BLUE:     byte_d = cur_q.blue;
			P_GREEN:    byte_d = cur_q.green;
			P_RED:      byte_d = cur_q.red;
			default:    byte_d = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(padrow) * PROD_W'(cur_q.height);
		if (load) begin
			cur_q <= head;
		end
		if (emit) begin
			byte_q <= byte_d;
			last_q <= done;
			fd_q   <= done && cur_q.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				pos_q <= head.header ? '0 : P_BLUE;
			end else if (emit) begin
				pos_q <= pos_q + 1'b1;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (bmp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_fd_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && fd_q |-> last_q) else $error("frame end off a run end");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_RUN |-> pos_q <= cur_q.last_pos) else $error("byte position overrun");
	a_skip_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		load && !head.header |=> pos_q == P_BLUE) else $error("header not skipped");

endmodule

`default_nettype wire

// ===== design/rgb565_to_bmp_stream_encoder_core.sv =====
// Top level of the RGB565 to 24-bit BMP stream encoder: APB registers,
// front end, command queue and back end. Depends on r2b_pkg, the two
// channel interfaces, r2b_front, r2b_fifo and r2b_back.
//
//   port   | dir   | handshake        | payload
//   -------+-------+------------------+--------------------------------------
//   pix    | sink  | valid/ready      | pixel[15:0] RGB565
//   bmp    | source| valid/ready      | out_byte[7:0], last_of_run, frame_done
//   apb    | slave | psel/penable     | paddr[2:0], pwdata/prdata[31:0]
//
// One byte per cycle out while bmp.ready holds: 3 bytes per pixel, 3 + w[1:0]
// at a row end, 54 more for the frame's first pixel; the back-end sequencer sets it.
// The front takes a pixel whenever the two-entry command queue has room.
// Reset restores width 240, height 176 and a pending header.
// A stalled bmp.ready holds the output register and fills the queue.
`default_nettype none

module rgb565_to_bmp_stream_encoder_core import r2b_pkg::*; #(
	parameter int MAX_DIMENSION = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	r2b_pix_if.sink     pix,
	r2b_byte_if.source  bmp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;
	logic             cfg_wr;
	logic             push;
	logic             pop;
	logic             full;
	logic             head_valid;
	cmd_t             push_cmd;
	cmd_t             head;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end
		return r;
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);
	assign eff_w  = clamp_dim(width_q);
	assign eff_h  = clamp_dim(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WIDTH) begin
				width_q <= pwdata[DIM_W-1:0];
			end else begin
				height_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	r2b_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.dim_w    (eff_w),
		.dim_h    (eff_h),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	r2b_fifo #(
		.DEPTH (2)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	r2b_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.bmp        (bmp)
	);

endmodule

`default_nettype wire
